@@ sv/rfbq_pkg.sv @@
// Package for the rotated force biquad filter core.
// Holds the sample formats, register indexes, request and result types and the sequencer states.
// Depends on nothing.
`default_nettype none

package rfbq_pkg;

   localparam int SAMPLE_WIDTH       = 24;
   localparam int ROT_WIDTH          = 16;
   localparam int ROT_FRAC           = 14;
   localparam int HIST_EXTRA         = 16;
   localparam int HIST_WIDTH         = SAMPLE_WIDTH + HIST_EXTRA;
   localparam int COEF_FRAC          = 30;
   localparam int COEF_WIDTH_DEFAULT = 32;

   localparam int COEF_B0_RESET = 259158;
   localparam int COEF_B1_RESET = 518317;
   localparam int COEF_B2_RESET = 259158;
   localparam int COEF_A1_RESET = 2099786146;
   localparam int COEF_A2_RESET = 1027080956;

   localparam logic [2:0] REG_B0 = 3'd0;
   localparam logic [2:0] REG_B1 = 3'd1;
   localparam logic [2:0] REG_B2 = 3'd2;
   localparam logic [2:0] REG_A1 = 3'd3;
   localparam logic [2:0] REG_A2 = 3'd4;

   localparam logic [2:0] TAP_B0    = 3'd0;
   localparam logic [2:0] TAP_B1    = 3'd1;
   localparam logic [2:0] TAP_B2    = 3'd2;
   localparam logic [2:0] TAP_A1_HI = 3'd3;
   localparam logic [2:0] TAP_A2_HI = 3'd4;
   localparam logic [2:0] TAP_A1_LO = 3'd5;
   localparam logic [2:0] TAP_A2_LO = 3'd6;

   localparam logic [2:0] ROT_LAST_TAP = 3'd2;
   localparam logic [1:0] AXIS_LAST    = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sensor_fx;
      logic signed [SAMPLE_WIDTH-1:0] sensor_fy;
      logic signed [SAMPLE_WIDTH-1:0] sensor_fz;
      logic signed [ROT_WIDTH-1:0]    rot_00;
      logic signed [ROT_WIDTH-1:0]    rot_01;
      logic signed [ROT_WIDTH-1:0]    rot_02;
      logic signed [ROT_WIDTH-1:0]    rot_10;
      logic signed [ROT_WIDTH-1:0]    rot_11;
      logic signed [ROT_WIDTH-1:0]    rot_12;
      logic signed [ROT_WIDTH-1:0]    rot_20;
      logic signed [ROT_WIDTH-1:0]    rot_21;
      logic signed [ROT_WIDTH-1:0]    rot_22;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] filt_x;
      logic signed [SAMPLE_WIDTH-1:0] filt_y;
      logic signed [SAMPLE_WIDTH-1:0] filt_z;
      logic signed [SAMPLE_WIDTH-1:0] raw_x;
      logic signed [SAMPLE_WIDTH-1:0] raw_y;
      logic signed [SAMPLE_WIDTH-1:0] raw_z;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_ROT_DRAIN,
      ST_PRELOAD,
      ST_FILTER,
      ST_FILT_DRAIN,
      ST_DELIVER
   } state_type;

endpackage

`default_nettype wire

@@ sv/rotated_force_biquad_filter_core.sv @@
// Top level of the rotated force biquad filter core.
// Uses rfbq_pkg for formats, register indexes, payload types and states.
//
// The core takes one request at a time and is ready for the next one in the
// same cycle that it raises the result. Each request takes nine products for
// the frame rotation and seven for each of the three biquad axes, all through
// one signed multiplier followed by one accumulator, plus a drain of that
// pipeline after the rotation and again after the filter, a preload step that
// seeds the histories while those of the last axis are zero, and a hand-over
// step for the result. A finished result waits in its own register, so the
// core is ready again while the previous result has not yet been taken; a
// later result waits in the hand-over step until that register is free.
`default_nettype none

module rotated_force_biquad_filter_core #(
   parameter int  COEF_WIDTH = rfbq_pkg::COEF_WIDTH_DEFAULT,
   localparam int CSR_DATA_W = (COEF_WIDTH > 32) ? 64 : 32,
   localparam int CSR_ADDR_W = (COEF_WIDTH > 32) ? 6 : 5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire rfbq_pkg::req_type     req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rfbq_pkg::rsp_type          rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int SW      = rfbq_pkg::SAMPLE_WIDTH;
   localparam int HW      = rfbq_pkg::HIST_WIDTH;
   localparam int HE      = rfbq_pkg::HIST_EXTRA;
   localparam int MB_W    = SW + 1;
   localparam int PROD_W  = COEF_WIDTH + MB_W;
   localparam int ACC_W   = COEF_WIDTH + SW + HE + 3;
   localparam int CSR_LSB = CSR_ADDR_W - 3;

   typedef struct packed {
      logic       valid;
      logic       first;
      logic       last;
      logic       shift;
      logic       neg;
      logic       filt;
      logic [1:0] axis;
   } mac_ctl_type;

   typedef struct packed {
      logic       valid;
      logic       filt;
      logic [1:0] axis;
   } fin_ctl_type;

   rfbq_pkg::state_type state_ff, state_in;
   rfbq_pkg::req_type   req_ff;
   rfbq_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff;
   logic [1:0]          axis_ff, axis_in;
   logic [2:0]          tap_ff, tap_in;

   logic signed [COEF_WIDTH-1:0] coef_b0_ff, coef_b1_ff, coef_b2_ff, coef_a1_ff, coef_a2_ff;
   logic [2:0]                   csr_index;
   logic                         csr_write;
   logic signed [COEF_WIDTH-1:0] csr_rd_coef;

   logic signed [COEF_WIDTH-1:0] mul_a;
   logic signed [MB_W-1:0]       mul_b;
   mac_ctl_type                  mac_in, mac_ff;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [ACC_W-1:0]      acc_ff, acc_in, prod_ext, prod_term;
   fin_ctl_type                  fin_ff;

   logic signed [ACC_W-1:0] fin_sum, fin_rnd;
   logic signed [SW-1:0]    fin_raw;
   logic signed [HW-1:0]    fin_hist;

   logic signed [SW-1:0]   raw_ff [3];
   logic signed [SW-1:0]   in_hist_one_ff [3];
   logic signed [SW-1:0]   in_hist_two_ff [3];
   logic signed [HW-1:0]   out_hist_one_ff [3];
   logic signed [HW-1:0]   out_hist_two_ff [3];
   logic signed [SW-1:0]   filt_val [3];
   logic signed [HW:0]     filt_sum [3];
   logic signed [15:0]     rot_mat [3][3];
   logic signed [MB_W-1:0] swapped [3];
   logic                   preload_hit;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:CSR_LSB];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff <= COEF_WIDTH'(rfbq_pkg::COEF_B0_RESET);
         coef_b1_ff <= COEF_WIDTH'(rfbq_pkg::COEF_B1_RESET);
         coef_b2_ff <= COEF_WIDTH'(rfbq_pkg::COEF_B2_RESET);
         coef_a1_ff <= COEF_WIDTH'(rfbq_pkg::COEF_A1_RESET);
         coef_a2_ff <= COEF_WIDTH'(rfbq_pkg::COEF_A2_RESET);
      end else if (csr_write) begin
         unique case (csr_index)
            rfbq_pkg::REG_B0: coef_b0_ff <= csr_pwdata[COEF_WIDTH-1:0];
            rfbq_pkg::REG_B1: coef_b1_ff <= csr_pwdata[COEF_WIDTH-1:0];
            rfbq_pkg::REG_B2: coef_b2_ff <= csr_pwdata[COEF_WIDTH-1:0];
            rfbq_pkg::REG_A1: coef_a1_ff <= csr_pwdata[COEF_WIDTH-1:0];
            rfbq_pkg::REG_A2: coef_a2_ff <= csr_pwdata[COEF_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         rfbq_pkg::REG_B0: csr_rd_coef = coef_b0_ff;
         rfbq_pkg::REG_B1: csr_rd_coef = coef_b1_ff;
         rfbq_pkg::REG_B2: csr_rd_coef = coef_b2_ff;
         rfbq_pkg::REG_A1: csr_rd_coef = coef_a1_ff;
         rfbq_pkg::REG_A2: csr_rd_coef = coef_a2_ff;
         default:          csr_rd_coef = '0;
      endcase
      csr_prdata = CSR_DATA_W'(csr_rd_coef);
   end

   // Sequencer: next state and step counters.
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      tap_in   = tap_ff;
      unique case (state_ff)
         rfbq_pkg::ST_IDLE: begin
            axis_in = '0;
            tap_in  = '0;
            if (req_valid) begin
               state_in = rfbq_pkg::ST_ROTATE;
            end
         end
         rfbq_pkg::ST_ROTATE: begin
            if (tap_ff == rfbq_pkg::ROT_LAST_TAP) begin
               tap_in  = '0;
               axis_in = axis_ff + 2'd1;
               if (axis_ff == rfbq_pkg::AXIS_LAST) begin
                  axis_in  = '0;
                  state_in = rfbq_pkg::ST_ROT_DRAIN;
               end
            end else begin
               tap_in = tap_ff + 3'd1;
            end
         end
         rfbq_pkg::ST_ROT_DRAIN: begin
            if (!mac_ff.valid && !fin_ff.valid) begin
               state_in = rfbq_pkg::ST_PRELOAD;
            end
         end
         rfbq_pkg::ST_PRELOAD: begin
            state_in = rfbq_pkg::ST_FILTER;
         end
         rfbq_pkg::ST_FILTER: begin
            if (tap_ff == rfbq_pkg::TAP_A2_LO) begin
               tap_in  = '0;
               axis_in = axis_ff + 2'd1;
               if (axis_ff == rfbq_pkg::AXIS_LAST) begin
                  axis_in  = '0;
                  state_in = rfbq_pkg::ST_FILT_DRAIN;
               end
            end else begin
               tap_in = tap_ff + 3'd1;
            end
         end
         rfbq_pkg::ST_FILT_DRAIN: begin
            if (!mac_ff.valid && !fin_ff.valid) begin
               state_in = rfbq_pkg::ST_DELIVER;
            end
         end
         rfbq_pkg::ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = rfbq_pkg::ST_IDLE;
            end
         end
         default: state_in = rfbq_pkg::ST_IDLE;
      endcase
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      rot_mat[0][0] = req_ff.rot_00;
      rot_mat[0][1] = req_ff.rot_01;
      rot_mat[0][2] = req_ff.rot_02;
      rot_mat[1][0] = req_ff.rot_10;
      rot_mat[1][1] = req_ff.rot_11;
      rot_mat[1][2] = req_ff.rot_12;
      rot_mat[2][0] = req_ff.rot_20;
      rot_mat[2][1] = req_ff.rot_21;
      rot_mat[2][2] = req_ff.rot_22;
      swapped[0]    = MB_W'(0) - MB_W'(req_ff.sensor_fy);
      swapped[1]    = MB_W'(req_ff.sensor_fx);
      swapped[2]    = MB_W'(req_ff.sensor_fz);

      req_ready    = (state_ff == rfbq_pkg::ST_IDLE);
      mul_a        = '0;
      mul_b        = '0;
      mac_in       = '0;
      mac_in.axis  = axis_ff;
      mac_in.first = (tap_ff == '0);
      unique case (state_ff)
         rfbq_pkg::ST_ROTATE: begin
            mul_a       = COEF_WIDTH'(rot_mat[axis_ff][tap_ff[1:0]]);
            mul_b       = swapped[tap_ff[1:0]];
            mac_in.valid = 1'b1;
            mac_in.last  = (tap_ff == rfbq_pkg::ROT_LAST_TAP);
         end
         rfbq_pkg::ST_FILTER: begin
            mac_in.valid = 1'b1;
            mac_in.filt  = 1'b1;
            mac_in.last  = (tap_ff == rfbq_pkg::TAP_A2_LO);
            unique case (tap_ff)
               rfbq_pkg::TAP_B0: begin
                  mul_a        = coef_b0_ff;
                  mul_b        = MB_W'(raw_ff[axis_ff]);
                  mac_in.shift = 1'b1;
               end
               rfbq_pkg::TAP_B1: begin
                  mul_a        = coef_b1_ff;
                  mul_b        = MB_W'(in_hist_one_ff[axis_ff]);
                  mac_in.shift = 1'b1;
               end
               rfbq_pkg::TAP_B2: begin
                  mul_a        = coef_b2_ff;
                  mul_b        = MB_W'(in_hist_two_ff[axis_ff]);
                  mac_in.shift = 1'b1;
               end
               rfbq_pkg::TAP_A1_HI: begin
                  mul_a        = coef_a1_ff;
                  mul_b        = MB_W'(signed'(out_hist_one_ff[axis_ff][HW-1:HE]));
                  mac_in.shift = 1'b1;
               end
               rfbq_pkg::TAP_A2_HI: begin
                  mul_a        = coef_a2_ff;
                  mul_b        = MB_W'(signed'(out_hist_two_ff[axis_ff][HW-1:HE]));
                  mac_in.shift = 1'b1;
                  mac_in.neg   = 1'b1;
               end
               rfbq_pkg::TAP_A1_LO: begin
                  mul_a = coef_a1_ff;
                  mul_b = MB_W'({1'b0, out_hist_one_ff[axis_ff][HE-1:0]});
               end
               rfbq_pkg::TAP_A2_LO: begin
                  mul_a      = coef_a2_ff;
                  mul_b      = MB_W'({1'b0, out_hist_two_ff[axis_ff][HE-1:0]});
                  mac_in.neg = 1'b1;
               end
               default: mac_in.valid = 1'b0;
            endcase
         end
         default: ;
      endcase
   end

   // Accumulate stage.
   always_comb begin
      prod_ext  = ACC_W'(prod_ff);
      prod_term = mac_ff.shift ? (prod_ext <<< HE) : prod_ext;
      if (mac_ff.neg) begin
         acc_in = (mac_ff.first ? ACC_W'(0) : acc_ff) - prod_term;
      end else begin
         acc_in = (mac_ff.first ? ACC_W'(0) : acc_ff) + prod_term;
      end
   end

   // Rounding and saturation of a finished sum.
   always_comb begin
      if (fin_ff.filt) begin
         fin_sum = acc_ff + (ACC_W'(1) <<< (rfbq_pkg::COEF_FRAC - 1));
         fin_rnd = fin_sum >>> rfbq_pkg::COEF_FRAC;
      end else begin
         fin_sum = acc_ff + (ACC_W'(1) <<< (rfbq_pkg::ROT_FRAC - 1));
         fin_rnd = fin_sum >>> rfbq_pkg::ROT_FRAC;
      end
      if ((&fin_rnd[ACC_W-1:SW-1]) || !(|fin_rnd[ACC_W-1:SW-1])) begin
         fin_raw = fin_rnd[SW-1:0];
      end else begin
         fin_raw = {fin_rnd[ACC_W-1], {(SW-1){~fin_rnd[ACC_W-1]}}};
      end
      if ((&fin_rnd[ACC_W-1:HW-1]) || !(|fin_rnd[ACC_W-1:HW-1])) begin
         fin_hist = fin_rnd[HW-1:0];
      end else begin
         fin_hist = {fin_rnd[ACC_W-1], {(HW-1){~fin_rnd[ACC_W-1]}}};
      end
   end

   // Filtered outputs from the newest output history.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         filt_sum[i] = (HW+1)'(out_hist_one_ff[i]) + (HW+1)'(1 << (HE - 1));
         if (filt_sum[i][HW] == filt_sum[i][HW-1]) begin
            filt_val[i] = filt_sum[i][HW-1:HE];
         end else begin
            filt_val[i] = {filt_sum[i][HW], {(SW-1){~filt_sum[i][HW]}}};
         end
      end
      rsp_in        = rsp_ff;
      rsp_in.filt_x = filt_val[0];
      rsp_in.filt_y = filt_val[1];
      rsp_in.filt_z = filt_val[2];
      rsp_in.raw_x  = raw_ff[0];
      rsp_in.raw_y  = raw_ff[1];
      rsp_in.raw_z  = raw_ff[2];
   end

   assign preload_hit = (out_hist_one_ff[2] == '0) && (out_hist_two_ff[2] == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfbq_pkg::ST_IDLE;
         axis_ff      <= '0;
         tap_ff       <= '0;
         mac_ff       <= '0;
         fin_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            in_hist_one_ff[i]  <= '0;
            in_hist_two_ff[i]  <= '0;
            out_hist_one_ff[i] <= '0;
            out_hist_two_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         tap_ff       <= tap_in;
         mac_ff       <= mac_in;
         fin_ff.valid <= mac_ff.valid && mac_ff.last;
         fin_ff.filt  <= mac_ff.filt;
         fin_ff.axis  <= mac_ff.axis;
         if (state_ff == rfbq_pkg::ST_DELIVER && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == rfbq_pkg::ST_PRELOAD && preload_hit) begin
            for (int i = 0; i < 3; i++) begin
               in_hist_one_ff[i]  <= raw_ff[i];
               in_hist_two_ff[i]  <= raw_ff[i];
               out_hist_one_ff[i] <= {raw_ff[i], {HE{1'b0}}};
               out_hist_two_ff[i] <= {raw_ff[i], {HE{1'b0}}};
            end
         end
         if (fin_ff.valid && fin_ff.filt) begin
            for (int i = 0; i < 3; i++) begin
               if (fin_ff.axis == 2'(i)) begin
                  in_hist_two_ff[i]  <= in_hist_one_ff[i];
                  in_hist_one_ff[i]  <= raw_ff[i];
                  out_hist_two_ff[i] <= out_hist_one_ff[i];
                  out_hist_one_ff[i] <= fin_hist;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      if (mac_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (fin_ff.valid && !fin_ff.filt) begin
         for (int i = 0; i < 3; i++) begin
            if (fin_ff.axis == 2'(i)) begin
               raw_ff[i] <= fin_raw;
            end
         end
      end
      if (state_ff == rfbq_pkg::ST_DELIVER && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
